FILE: rtl/qpid_pkg.sv
// ----------------------------------------------------------------------------
// qpid_pkg
// Shared types, constants and saturating arithmetic for the Q1.31 PID block.
// ----------------------------------------------------------------------------
package qpid_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_ADDR_W    = 2;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 8;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV = 2'd2;

  localparam logic [DATA_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q31_MIN = 32'h8000_0000;

  // +/- 2^30 in 64-bit two's complement
  localparam logic [2*DATA_W-1:0] RND_POS = 64'h0000_0000_4000_0000;
  localparam logic [2*DATA_W-1:0] RND_NEG = 64'hFFFF_FFFF_C000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] prop;
    logic [DATA_W-1:0] integ;
    logic [DATA_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic [DATA_W-1:0] err;
    logic [DATA_W-1:0] slope;
  } mid_item_t;

  // clamp a 33-bit signed value into Q1.31
  function automatic logic [DATA_W-1:0] sat_33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? Q31_MIN : Q31_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // clamp a 34-bit signed value into Q1.31
  function automatic logic [DATA_W-1:0] sat_34(input logic [DATA_W+1:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W+1]) begin
      r = (v[DATA_W:DATA_W-1] == 2'b11) ? v[DATA_W-1:0] : Q31_MIN;
    end else begin
      r = (v[DATA_W:DATA_W-1] == 2'b00) ? v[DATA_W-1:0] : Q31_MAX;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat_33(s);
  endfunction

  // add +/-2^30 by sign, then floor shift by 31; result spans 33 bits
  function automatic logic [DATA_W:0] round_q(input logic [2*DATA_W-1:0] prod);
    logic [2*DATA_W-1:0] r;
    r = prod + (prod[2*DATA_W-1] ? RND_NEG : RND_POS);
    return r[2*DATA_W-1:DATA_W-1];
  endfunction

endpackage

FILE: rtl/qpid_fifo.sv
// ----------------------------------------------------------------------------
// qpid_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module qpid_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_xfer;
  logic             rd_xfer;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_xfer = wr_en && !full;
  assign rd_xfer = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_xfer) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_xfer) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_xfer) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_xfer, rd_xfer})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/qpid_front.sv
// ----------------------------------------------------------------------------
// qpid_front
// Accepts samples, forms the saturated error and queues it with the slope for the back end.
// ----------------------------------------------------------------------------
module qpid_front #(
  parameter int MID_DEPTH = qpid_pkg::MID_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [qpid_pkg::DATA_W-1:0] target,
  input  logic [qpid_pkg::DATA_W-1:0] measured,
  input  logic [qpid_pkg::DATA_W-1:0] slope,
  output logic                        item_valid,
  output qpid_pkg::mid_item_t         item,
  input  logic                        item_take
);

  localparam int W = qpid_pkg::DATA_W;

  logic [W:0]          diff;
  qpid_pkg::mid_item_t wr_item;
  logic                mid_empty;

  assign diff          = {target[W-1], target} - {measured[W-1], measured};
  assign wr_item.err   = qpid_pkg::sat_33(diff);
  assign wr_item.slope = slope;
  assign item_valid    = !mid_empty;

  qpid_fifo #(
    .WIDTH($bits(qpid_pkg::mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(wr_item),
    .full   (full),
    .rd_en  (item_take),
    .rd_data(item),
    .empty  (mid_empty)
  );

endmodule

FILE: rtl/qpid_back.sv
// ----------------------------------------------------------------------------
// qpid_back
// Multiply, round, integrate and sum pipeline feeding the result queue.
// ----------------------------------------------------------------------------
module qpid_back #(
  parameter int OUT_DEPTH = qpid_pkg::OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  qpid_pkg::gains_t            gains,
  input  logic                        item_valid,
  input  qpid_pkg::mid_item_t         item,
  output logic                        item_take,
  output logic [qpid_pkg::DATA_W-1:0] drive,
  output logic                        empty,
  input  logic                        pop
);

  localparam int W  = qpid_pkg::DATA_W;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  // credits: items in flight plus items in the result queue
  logic [CW-1:0]      reserved;
  logic               issue;
  logic               out_rd;

  logic               v1, v2, v3, v4;
  logic signed [2*W-1:0] prod_p, prod_i, prod_d;
  logic [W-1:0]       p2, d2;
  logic [W:0]         iq2;
  logic [W-1:0]       integrator;
  logic [W-1:0]       integ_next;
  logic [W-1:0]       p3, d3, i3;
  logic [W-1:0]       s4, d4;
  logic [W-1:0]       out_data;

  assign issue     = item_valid && (reserved != CW'(OUT_DEPTH));
  assign item_take = issue;
  assign out_rd    = pop && !empty;

  assign integ_next = qpid_pkg::sat_34({integrator[W-1], integrator[W-1], integrator}
                                       + {iq2[W], iq2});
  assign out_data   = qpid_pkg::add_sat(s4, d4);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      unique case ({issue, out_rd})
        2'b10:   reserved <= reserved + 1'b1;
        2'b01:   reserved <= reserved - 1'b1;
        default: reserved <= reserved;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      integrator <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v2) begin
        integrator <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    // products
    prod_p <= $signed(gains.prop)  * $signed(item.err);
    prod_i <= $signed(gains.integ) * $signed(item.err);
    prod_d <= $signed(gains.deriv) * $signed(item.slope);
    // rounding; the integral product stays unsaturated
    p2  <= qpid_pkg::sat_33(qpid_pkg::round_q(prod_p));
    d2  <= qpid_pkg::sat_33(qpid_pkg::round_q(prod_d));
    iq2 <= qpid_pkg::round_q(prod_i);
    // integrator update
    p3 <= p2;
    d3 <= d2;
    i3 <= integ_next;
    // P + I
    s4 <= qpid_pkg::add_sat(p3, i3);
    d4 <= d3;
  end

  qpid_fifo #(
    .WIDTH(W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (v4),
    .wr_data(out_data),
    .full   (),
    .rd_en  (pop),
    .rd_data(drive),
    .empty  (empty)
  );

endmodule

FILE: rtl/q31_pid_update.sv
// ----------------------------------------------------------------------------
// q31_pid_update
// Q1.31 PID controller step: saturated error, rounded P/I/D terms, sum.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while full is low and returns one drive value
// per sample, in order. A sample pushed into an idle block passes through the
// mid queue, then multiply, round, integrate, P+I stages, then the P+I+D add
// into the result queue. The rate of one per cycle is set by the integrator's
// single saturating add, and holds while results are popped and OUT_DEPTH is
// 6 or more; the back end issues only against free result-queue credits, so a
// stall on either side just fills the queues. Gains are to be written through
// cfg_wen/cfg_addr/cfg_data only while no sample is in flight, which the block
// does not enforce; an index beyond the deriv gain is ignored.
module q31_pid_update #(
  parameter int MID_DEPTH = qpid_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = qpid_pkg::OUT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [qpid_pkg::DATA_W-1:0] target,
  input  logic signed [qpid_pkg::DATA_W-1:0] measured,
  input  logic signed [qpid_pkg::DATA_W-1:0] slope,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [qpid_pkg::DATA_W-1:0] drive,
  input  logic                              cfg_wen,
  input  logic [qpid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [qpid_pkg::DATA_W-1:0]        cfg_data
);

  qpid_pkg::gains_t    gains;
  qpid_pkg::mid_item_t item;
  logic                item_valid;
  logic                item_take;
  logic [qpid_pkg::DATA_W-1:0] drive_raw;

  assign drive = drive_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        qpid_pkg::REG_PROP:  gains.prop  <= cfg_data;
        qpid_pkg::REG_INTEG: gains.integ <= cfg_data;
        qpid_pkg::REG_DERIV: gains.deriv <= cfg_data;
        default:             gains       <= gains;
      endcase
    end
  end

  qpid_front #(
    .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .target    (target),
    .measured  (measured),
    .slope     (slope),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take)
  );

  qpid_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .drive     (drive_raw),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: rtl/qpid_checker.sv
// ----------------------------------------------------------------------------
// qpid_checker
// Port-level checks for q31_pid_update, attached by bind.
// ----------------------------------------------------------------------------
module qpid_checker #(
  parameter int MID_DEPTH = qpid_pkg::MID_DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [qpid_pkg::DATA_W-1:0] drive
);

  // samples accepted whose results are not yet transferred out
  logic [15:0] outstanding;
  logic        in_xfer;
  logic        out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 16'(in_xfer) - 16'(out_xfer);
    end
  end

  a_reset_flags: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queue flags wrong after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (outstanding == '0) |-> empty)
    else $error("result offered with no sample outstanding");

  a_full_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    full |-> (outstanding >= 16'(MID_DEPTH)))
    else $error("full raised with mid queue not filled");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    ((outstanding == '0) && in_xfer) |=> empty ##1 empty ##1 empty ##1 empty)
    else $error("result appeared before pipeline latency");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(drive)))
    else $error("waiting result changed without transfer");

endmodule

bind q31_pid_update qpid_checker #(
  .MID_DEPTH(MID_DEPTH)
) u_qpid_checker (
  .clk  (clk),
  .rst  (rst),
  .push (push),
  .full (full),
  .pop  (pop),
  .empty(empty),
  .drive(drive)
);
